>>> rtl/trl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trl_pkg: shared types and constants of the text run layout block
// Command codes, character codes, register indexes, register reset values
// and the command and status groups between the controller and datapath.
// ----------------------------------------------------------------------------
package trl_pkg;

  // Default widths of coordinates and character indices.
  localparam int TRL_COORD_BITS = 12;
  localparam int TRL_INDEX_BITS = 16;

  // Input command codes.
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_CHAR  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CODE_TAB   = 8'd9;
  localparam logic [7:0] CODE_NL    = 8'd10;
  localparam logic [7:0] CODE_SPACE = 8'd32;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_W  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CH = 3'd5;

  // Register values after reset.
  localparam logic [11:0] RST_LEFT   = 12'd0;
  localparam logic [11:0] RST_RIGHT  = 12'd800;
  localparam logic [11:0] RST_BOTTOM = 12'd1024;
  localparam logic [7:0]  RST_LINE_H = 8'd16;
  localparam logic [11:0] RST_TAB_W  = 12'd72;
  localparam logic [7:0]  RST_MAX_CH = 8'd127;

  // Kinds of segment the datapath can emit.
  localparam logic [2:0] EK_END     = 3'd0;
  localparam logic [2:0] EK_NEWLINE = 3'd1;
  localparam logic [2:0] EK_WRAP    = 3'd2;
  localparam logic [2:0] EK_FLUSH   = 3'd3;
  localparam logic [2:0] EK_TAB     = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic       begin_job;
    logic       end_job;
    logic       advance;
    logic       div_start;
    logic       div_step;
    logic       emit;
    logic [2:0] kind;
  } trl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] item_cmd;
    logic       live;
    logic       is_nl;
    logic       is_tab;
    logic       run_nonempty;
    logic       char_wraps;
    logic       tab_wraps;
    logic       wrap_off;
    logic       div_last;
    logic       slot_free;
  } trl_stat_t;

endpackage

>>> rtl/trl_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trl_ifs: request channels of the text run layout block
// The input channel carries layout commands and characters, the output
// channel carries drawable segments; both use a valid/ready handshake.
// ----------------------------------------------------------------------------
interface trl_in_if import trl_pkg::*; #(
  parameter int COORD_BITS = TRL_COORD_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            cmd;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [7:0]            char_code;
  logic [7:0]            char_width;

  modport source (output valid, cmd, start_x, start_y, char_code, char_width,
                  input ready);
  modport sink (input valid, cmd, start_x, start_y, char_code, char_width,
                output ready);
endinterface

interface trl_out_if import trl_pkg::*; #(
  parameter int COORD_BITS = TRL_COORD_BITS,
  parameter int INDEX_BITS = TRL_INDEX_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] seg_x0;
  logic [COORD_BITS-1:0] seg_y;
  logic [COORD_BITS-1:0] seg_x1;
  logic [INDEX_BITS-1:0] seg_first;
  logic [INDEX_BITS-1:0] seg_count;
  logic                  complete;
  logic                  off_screen;
  logic                  overwide;
  logic                  last;

  modport source (output valid, seg_x0, seg_y, seg_x1, seg_first, seg_count,
                  complete, off_screen, overwide, last, input ready);
  modport sink (input valid, seg_x0, seg_y, seg_x1, seg_first, seg_count,
                complete, off_screen, overwide, last, output ready);
endinterface

>>> rtl/trl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trl_ctrl: sequencer of the text run layout block
// Takes one request at a time, decodes it from datapath status and steps
// the datapath through ends, newlines, run flushes, line wraps and tab stops.
// ----------------------------------------------------------------------------
module trl_ctrl import trl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  trl_stat_t stat,
  output trl_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_END       = 4'd2;
  localparam logic [3:0] S_NEWLINE   = 4'd3;
  localparam logic [3:0] S_WRAP_CHAR = 4'd4;
  localparam logic [3:0] S_PLACE     = 4'd5;
  localparam logic [3:0] S_FLUSH     = 4'd6;
  localparam logic [3:0] S_DIV_START = 4'd7;
  localparam logic [3:0] S_DIV       = 4'd8;
  localparam logic [3:0] S_TAB_CHECK = 4'd9;
  localparam logic [3:0] S_WRAP_TAB  = 4'd10;
  localparam logic [3:0] S_TAB_SEG   = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.item_cmd)
          CMD_BEGIN: begin
            cmd.begin_job = 1'b1;
            state_nxt     = S_IDLE;
          end
          CMD_END: begin
            if (stat.live) begin
              state_nxt = S_END;
            end else begin
              cmd.end_job = 1'b1;
              state_nxt   = S_IDLE;
            end
          end
          CMD_CHAR: begin
            if (!stat.live) begin
              state_nxt = S_IDLE;
            end else if (stat.is_nl) begin
              state_nxt = S_NEWLINE;
            end else if (stat.is_tab) begin
              state_nxt = stat.run_nonempty ? S_FLUSH : S_DIV_START;
            end else if (stat.char_wraps) begin
              state_nxt = S_WRAP_CHAR;
            end else begin
              state_nxt = S_PLACE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_END: begin
        cmd.emit = 1'b1;
        cmd.kind = EK_END;
        if (stat.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_NEWLINE: begin
        cmd.emit = 1'b1;
        cmd.kind = EK_NEWLINE;
        if (stat.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_WRAP_CHAR: begin
        cmd.emit = 1'b1;
        cmd.kind = EK_WRAP;
        if (stat.slot_free) begin
          state_nxt = stat.wrap_off ? S_IDLE : S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.advance = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_FLUSH: begin
        cmd.emit = 1'b1;
        cmd.kind = EK_FLUSH;
        if (stat.slot_free) begin
          state_nxt = S_DIV_START;
        end
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_TAB_CHECK;
        end
      end
      S_TAB_CHECK: begin
        state_nxt = stat.tab_wraps ? S_WRAP_TAB : S_TAB_SEG;
      end
      S_WRAP_TAB: begin
        cmd.emit = 1'b1;
        cmd.kind = EK_WRAP;
        if (stat.slot_free) begin
          // The pen is now at the left edge, so the search gives one stop in.
          state_nxt = stat.wrap_off ? S_IDLE : S_DIV_START;
        end
      end
      S_TAB_SEG: begin
        cmd.emit = 1'b1;
        cmd.kind = EK_TAB;
        if (stat.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/trl_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trl_dpath: datapath of the text run layout block
// Holds the registers, the pen and run state, a bit-serial remainder unit
// for tab stops and the output register that presents each segment.
// ----------------------------------------------------------------------------
module trl_dpath import trl_pkg::*; #(
  parameter int COORD_BITS = TRL_COORD_BITS,
  parameter int INDEX_BITS = TRL_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            in_cmd,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [7:0]            in_char_code,
  input  logic [7:0]            in_char_width,
  input  trl_cmd_t              cmd,
  output trl_stat_t             stat,
  trl_out_if.source             out_chan
);

  localparam int CW    = COORD_BITS;
  localparam int XW    = COORD_BITS + 1;
  localparam int IW    = INDEX_BITS;
  localparam int CNT_W = $clog2(COORD_BITS);

  // Configuration registers.
  logic [11:0] left_r, right_r, bottom_r, tab_w_r;
  logic [7:0]  line_h_r, max_ch_r;

  // Latched request.
  logic [1:0]    it_cmd_r;
  logic [CW-1:0] it_sx_r, it_sy_r;
  logic [7:0]    it_code_r, it_w_r;

  // Layout state.
  logic [CW-1:0] pen_r, line_y_r, run_x_r;
  logic [IW-1:0] run_first_r, run_count_r, char_idx_r;
  logic          active_r, stopped_r, wide_r;
  logic [CW-1:0] pen_nxt, line_y_nxt, run_x_nxt;
  logic [IW-1:0] run_first_nxt, run_count_nxt, char_idx_nxt;
  logic          active_nxt, stopped_nxt, wide_nxt;

  // Remainder unit.
  logic [CW-1:0]    dq_r, rem_r;
  logic [CNT_W-1:0] div_cnt_r;
  logic [XW-1:0]    trial, trial_diff;

  // Output register.
  logic          out_valid_r;
  logic [CW-1:0] o_x0_r, o_y_r, o_x1_r;
  logic [IW-1:0] o_first_r, o_count_r;
  logic          o_done_r, o_off_r, o_wide_r, o_last_r;
  logic [CW-1:0] e_x0, e_x1;
  logic [IW-1:0] e_first, e_count;
  logic          e_done, e_off, e_wide, e_last;

  // Derived values.
  logic [CW-1:0] left_c, right_c, bottom_c, tab_c, tw, pen_dist, t_tab_sat, t_char_sat;
  logic [XW-1:0] t_char, t_tab, ny;
  logic [IW-1:0] run_count_inc, char_idx_inc;
  logic          line_empty, printable, pen_ge_left, char_over, tab_over;
  logic          slot_free, emit_fire;

  assign left_c   = CW'(left_r);
  assign right_c  = CW'(right_r);
  assign bottom_c = CW'(bottom_r);
  assign tab_c    = CW'(tab_w_r);
  assign tw       = (tab_c == '0) ? CW'(1) : tab_c;

  assign line_empty    = (pen_r == left_c) && (run_count_r == '0);
  assign printable     = (it_code_r >= CODE_SPACE) && (it_code_r <= max_ch_r);
  assign run_count_inc = run_count_r + IW'(1);
  assign char_idx_inc  = char_idx_r + IW'(1);

  // Pen after a printable character, and the overflow check.
  assign t_char     = {1'b0, pen_r} + XW'(it_w_r);
  assign char_over  = t_char > {1'b0, right_c};
  assign t_char_sat = t_char[CW] ? {CW{1'b1}} : t_char[CW-1:0];

  // Y of the next line and whether it falls off the frame.
  assign ny = {1'b0, line_y_r} + XW'(line_h_r);

  // Next tab stop from the remainder of the pen distance to the left edge.
  assign pen_ge_left = pen_r >= left_c;
  assign pen_dist    = pen_ge_left ? (pen_r - left_c) : (left_c - pen_r);
  assign t_tab       = (pen_ge_left ? ({1'b0, pen_r} - {1'b0, rem_r})
                                    : ({1'b0, pen_r} + {1'b0, rem_r})) + {1'b0, tw};
  assign tab_over    = t_tab > {1'b0, right_c};
  assign t_tab_sat   = t_tab[CW] ? {CW{1'b1}} : t_tab[CW-1:0];

  // One restoring step of the remainder: shift in a bit, subtract if it fits.
  assign trial      = {rem_r, dq_r[CW-1]};
  assign trial_diff = trial - {1'b0, tw};

  assign slot_free = !out_valid_r || out_chan.ready;
  assign emit_fire = cmd.emit && slot_free;

  // Status to the controller.
  always_comb begin
    stat.item_cmd     = it_cmd_r;
    stat.live         = active_r && !stopped_r;
    stat.is_nl        = (it_code_r == CODE_NL);
    stat.is_tab       = (it_code_r == CODE_TAB);
    stat.run_nonempty = (run_count_r != '0);
    stat.char_wraps   = printable && char_over && !line_empty;
    stat.tab_wraps    = tab_over && !line_empty;
    stat.wrap_off     = ny >= {1'b0, bottom_c};
    stat.div_last     = (div_cnt_r == CNT_W'(COORD_BITS - 1));
    stat.slot_free    = slot_free;
  end

  // Segment fields for each kind of emission.
  always_comb begin
    e_x0    = run_x_r;
    e_x1    = pen_r;
    e_first = run_first_r;
    e_count = run_count_r;
    e_done  = 1'b0;
    e_off   = 1'b0;
    e_wide  = wide_r;
    e_last  = 1'b1;
    case (cmd.kind)
      EK_END: begin
        if (line_y_r < bottom_c) begin
          e_done = 1'b1;
        end else begin
          // The current line is already below the frame.
          e_x0    = pen_r;
          e_first = char_idx_r;
          e_count = '0;
          e_off   = 1'b1;
          e_wide  = 1'b0;
        end
      end
      EK_NEWLINE: begin
        e_x1    = right_c;
        e_count = run_count_inc;
        e_off   = stat.wrap_off;
      end
      EK_WRAP: begin
        // Only a wrapping tab has a segment of its own still to follow.
        e_x1   = right_c;
        e_off  = stat.wrap_off;
        e_last = stat.wrap_off || !stat.is_tab;
      end
      EK_FLUSH: begin
        e_last = 1'b0;
      end
      EK_TAB: begin
        e_x1    = t_tab_sat;
        e_first = char_idx_r;
        e_count = IW'(1);
        e_wide  = tab_over;
      end
      default: begin
        e_last = 1'b1;
      end
    endcase
  end

  // Next layout state.
  always_comb begin
    pen_nxt       = pen_r;
    line_y_nxt    = line_y_r;
    run_x_nxt     = run_x_r;
    run_first_nxt = run_first_r;
    run_count_nxt = run_count_r;
    char_idx_nxt  = char_idx_r;
    active_nxt    = active_r;
    stopped_nxt   = stopped_r;
    wide_nxt      = wide_r;
    if (cmd.begin_job) begin
      pen_nxt       = it_sx_r;
      line_y_nxt    = it_sy_r;
      run_x_nxt     = it_sx_r;
      run_first_nxt = '0;
      run_count_nxt = '0;
      char_idx_nxt  = '0;
      active_nxt    = 1'b1;
      stopped_nxt   = 1'b0;
      wide_nxt      = 1'b0;
    end else if (cmd.end_job) begin
      active_nxt = 1'b0;
    end else if (cmd.advance) begin
      // Control codes are counted but take no width.
      if (printable) begin
        pen_nxt = t_char_sat;
        if (char_over) begin
          wide_nxt = 1'b1;
        end
      end
      run_count_nxt = run_count_inc;
      char_idx_nxt  = char_idx_inc;
    end else if (emit_fire) begin
      case (cmd.kind)
        EK_END: begin
          active_nxt = 1'b0;
        end
        EK_NEWLINE, EK_WRAP: begin
          // Start a new line at the left edge.
          line_y_nxt    = ny[CW-1:0];
          run_x_nxt     = left_c;
          pen_nxt       = left_c;
          run_count_nxt = '0;
          wide_nxt      = 1'b0;
          if (stat.wrap_off) begin
            stopped_nxt = 1'b1;
          end
          if (cmd.kind == EK_NEWLINE) begin
            char_idx_nxt  = char_idx_inc;
            run_first_nxt = char_idx_inc;
          end else begin
            run_first_nxt = char_idx_r;
          end
        end
        EK_FLUSH: begin
          run_x_nxt     = pen_r;
          run_first_nxt = char_idx_r;
          run_count_nxt = '0;
          wide_nxt      = 1'b0;
        end
        EK_TAB: begin
          pen_nxt       = t_tab_sat;
          run_x_nxt     = t_tab_sat;
          char_idx_nxt  = char_idx_inc;
          run_first_nxt = char_idx_inc;
        end
        default: begin
          active_nxt = active_r;
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= RST_LEFT;
      right_r  <= RST_RIGHT;
      bottom_r <= RST_BOTTOM;
      line_h_r <= RST_LINE_H;
      tab_w_r  <= RST_TAB_W;
      max_ch_r <= RST_MAX_CH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT:   left_r   <= cfg_data;
        CFG_RIGHT:  right_r  <= cfg_data;
        CFG_BOTTOM: bottom_r <= cfg_data;
        CFG_LINE_H: line_h_r <= cfg_data[7:0];
        CFG_TAB_W:  tab_w_r  <= cfg_data;
        CFG_MAX_CH: max_ch_r <= cfg_data[7:0];
        default: begin
          left_r <= left_r;
        end
      endcase
    end
  end

  // Latch the accepted request.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_cmd_r  <= in_cmd;
      it_sx_r   <= in_start_x;
      it_sy_r   <= in_start_y;
      it_code_r <= in_char_code;
      it_w_r    <= in_char_width;
    end
  end

  // Layout state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r       <= '0;
      line_y_r    <= '0;
      run_x_r     <= '0;
      run_first_r <= '0;
      run_count_r <= '0;
      char_idx_r  <= '0;
      active_r    <= 1'b0;
      stopped_r   <= 1'b0;
      wide_r      <= 1'b0;
    end else begin
      pen_r       <= pen_nxt;
      line_y_r    <= line_y_nxt;
      run_x_r     <= run_x_nxt;
      run_first_r <= run_first_nxt;
      run_count_r <= run_count_nxt;
      char_idx_r  <= char_idx_nxt;
      active_r    <= active_nxt;
      stopped_r   <= stopped_nxt;
      wide_r      <= wide_nxt;
    end
  end

  // Remainder unit: one bit of the pen distance per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq_r  <= pen_dist;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dq_r  <= {dq_r[CW-2:0], 1'b0};
      rem_r <= (trial >= {1'b0, tw}) ? trial_diff[CW-1:0] : trial[CW-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      o_x0_r    <= e_x0;
      o_y_r     <= line_y_r;
      o_x1_r    <= e_x1;
      o_first_r <= e_first;
      o_count_r <= e_count;
      o_done_r  <= e_done;
      o_off_r   <= e_off;
      o_wide_r  <= e_wide;
      o_last_r  <= e_last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.seg_x0     = o_x0_r;
  assign out_chan.seg_y      = o_y_r;
  assign out_chan.seg_x1     = o_x1_r;
  assign out_chan.seg_first  = o_first_r;
  assign out_chan.seg_count  = o_count_r;
  assign out_chan.complete   = o_done_r;
  assign out_chan.off_screen = o_off_r;
  assign out_chan.overwide   = o_wide_r;
  assign out_chan.last       = o_last_r;

endmodule

>>> rtl/text_run_layout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_run_layout: text frame layout engine
// Lays out a stream of characters in a frame and emits drawable segments.
//
//   channel   direction  carries
//   in_chan   in         begin, character and end requests
//   out_chan  out        segments, none to three per request
//   cfg_*     in         register writes, no read-back
//
// Requests are taken one at a time. A tab waits for the remainder unit,
// which finds the tab stop one bit a cycle; a tab that wraps runs it
// twice, once on each line.
// Reset loads the register defaults and leaves no layout active.
// While the output register holds an untaken segment, the next one waits.
// ----------------------------------------------------------------------------
module text_run_layout import trl_pkg::*; #(
  parameter int COORD_BITS = TRL_COORD_BITS,
  parameter int INDEX_BITS = TRL_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  trl_in_if.sink                in_chan,
  trl_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  trl_cmd_t  cmd;
  trl_stat_t stat;
  logic      in_ready;

  assign in_chan.ready = in_ready;

  // Sequencer.
  trl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath with the output register.
  trl_dpath #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_cmd        (in_chan.cmd),
    .in_start_x    (in_chan.start_x),
    .in_start_y    (in_chan.start_y),
    .in_char_code  (in_chan.char_code),
    .in_char_width (in_chan.char_width),
    .cmd           (cmd),
    .stat          (stat),
    .out_chan      (out_chan)
  );

  // A segment loaded into a free output register is shown the next cycle.
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && stat.slot_free |=> out_chan.valid)
    else $error("emitted segment not presented");

  // A begin request never produces a segment right after it is taken.
  a_begin_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && (in_chan.cmd == CMD_BEGIN) && !out_chan.valid
    |=> !out_chan.valid)
    else $error("begin request produced a segment");

  // While ready for a request, the sequencer neither emits nor divides.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !cmd.emit && !cmd.div_step)
    else $error("work issued while waiting for a request");

endmodule
